/* design/ttlp_pkg.sv */
// Shared types and constants for the touch tap / long-press classifier.
// No dependencies; imported by every module of the block.
package ttlp_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MOVE_W  = 17;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [TIME_W-1:0] LONG_PRESS_RST = TIME_W'(1000);
    localparam logic [MOVE_W-1:0] MAX_MOVE_RST   = MOVE_W'(30);
    localparam logic [TIME_W-1:0] DEBOUNCE_RST   = TIME_W'(100);

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2,
        EV_MOVE = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        GEST_NONE    = 2'd0,
        GEST_PRESSED = 2'd1,
        GEST_QUICK   = 2'd2,
        GEST_LONG    = 2'd3
    } gesture_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_MAX_MOVE   = 2'd1,
        CFG_DEBOUNCE   = 2'd2
    } cfg_index_t;

    // Configuration register values
    typedef struct packed {
        logic [TIME_W-1:0] hold_limit;
        logic [MOVE_W-1:0] max_move;
        logic [TIME_W-1:0] debounce_ms;
    } ttlp_cfg_t;

    // One touch event
    typedef struct packed {
        event_kind_t        kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  now;
    } ttlp_event_t;

    // One classification result
    typedef struct packed {
        logic               gvalid;
        gesture_t           code;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               touching;
        gesture_t           recorded;
    } ttlp_result_t;

endpackage

/* design/touch_tap_long_press_classifier_top.sv */
// Top level of the touch tap / long-press classifier.
// Depends on ttlp_pkg, ttlp_cfg_regs, ttlp_in_stage, ttlp_classifier, ttlp_out_stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  input    | in_valid / in_stall        | event_kind, pos_x, pos_y, now_ms
//  output   | out_valid / out_stall      | gesture_valid, gesture_code, gesture_x,
//           |                            | gesture_y, touching, recorded_gesture
//  config   | cfg_write                  | cfg_index, cfg_data
//
// One event per cycle sustained while the output is not stalled. An accepted
// event is held in the input register, then classified into the result register
// when it advances, and offered on the output from there.
// Touch state updates as an event moves from the input to the result register.
// Reset (rst_n low, asynchronous) empties both registers and restores state and
// configuration defaults. An output stall holds the result; the input register
// still takes one more event before in_stall rises.
module touch_tap_long_press_classifier_top
    import ttlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         event_kind,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [TIME_W-1:0]  now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               gesture_valid,
    output logic [1:0]         gesture_code,
    output logic [COORD_W-1:0] gesture_x,
    output logic [COORD_W-1:0] gesture_y,
    output logic               touching,
    output logic [1:0]         recorded_gesture,
    input  logic               cfg_write,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    ttlp_cfg_t    cfg;
    ttlp_event_t  evt_in;
    ttlp_event_t  evt;
    logic         evt_valid;
    logic         accept;
    logic         advance;
    ttlp_result_t res_comb;
    ttlp_result_t res;

    // Pipeline flow control
    assign advance  = evt_valid && (!out_valid || !out_stall);
    assign in_stall = evt_valid && !advance;
    assign accept   = in_valid && !in_stall;

    assign evt_in.kind = event_kind_t'(event_kind);
    assign evt_in.x    = pos_x;
    assign evt_in.y    = pos_y;
    assign evt_in.now  = now_ms;

    ttlp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttlp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .evt_in    (evt_in),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    ttlp_classifier u_cls (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .evt   (evt),
        .cfg   (cfg),
        .res   (res_comb)
    );

    ttlp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .out_stall (out_stall),
        .res_in    (res_comb),
        .out_valid (out_valid),
        .res       (res)
    );

    // Result fields
    assign gesture_valid    = res.gvalid;
    assign gesture_code     = res.code;
    assign gesture_x        = res.x;
    assign gesture_y        = res.y;
    assign touching         = res.touching;
    assign recorded_gesture = res.recorded;

endmodule

/* design/ttlp_cfg_regs.sv */
// Configuration registers of the classifier, written through a plain write port.
// Depends on ttlp_pkg.
module ttlp_cfg_regs
    import ttlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output ttlp_cfg_t         cfg
);

    ttlp_cfg_t cfg_reg;
    ttlp_cfg_t cfg_next;

    // Decode the register index; unknown indexes leave everything unchanged
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LONG_PRESS: cfg_next.hold_limit    = cfg_data[TIME_W-1:0];
                CFG_MAX_MOVE:   cfg_next.max_move      = cfg_data[MOVE_W-1:0];
                CFG_DEBOUNCE:   cfg_next.debounce_ms   = cfg_data[TIME_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_limit    <= LONG_PRESS_RST;
            cfg_reg.max_move      <= MAX_MOVE_RST;
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ttlp_in_stage.sv */
// Input register of the classifier pipeline: holds one accepted event.
// Depends on ttlp_pkg.
module ttlp_in_stage
    import ttlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        advance,
    input  ttlp_event_t evt_in,
    output logic        evt_valid,
    output ttlp_event_t evt
);

    logic        valid_reg;
    logic        valid_next;
    ttlp_event_t evt_reg;

    // Occupancy: filled by an accepted transaction, emptied when it moves on
    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            evt_reg <= evt_in;
    end

    assign evt_valid = valid_reg;
    assign evt       = evt_reg;

endmodule

/* design/ttlp_classifier.sv */
// Touch state and gesture classification: updates the touch state for one
// event and forms its result. Depends on ttlp_pkg.
module ttlp_classifier
    import ttlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  ttlp_event_t  evt,
    input  ttlp_cfg_t    cfg,
    output ttlp_result_t res
);

    logic               is_down_reg, is_down_next;
    logic [COORD_W-1:0] start_x_reg, start_x_next;
    logic [COORD_W-1:0] start_y_reg, start_y_next;
    logic [COORD_W-1:0] latest_x_reg, latest_x_next;
    logic [COORD_W-1:0] latest_y_reg, latest_y_next;
    logic [TIME_W-1:0]  press_time_reg, press_time_next;
    gesture_t           saved_reg, saved_next;

    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [MOVE_W-1:0]  travel;
    logic [TIME_W-1:0]  elapsed;
    gesture_t           release_g;

    // Movement and elapsed time since the press
    always_comb
    begin
        dx      = (start_x_reg >= latest_x_reg) ? (start_x_reg - latest_x_reg)
                                                : (latest_x_reg - start_x_reg);
        dy      = (start_y_reg >= latest_y_reg) ? (start_y_reg - latest_y_reg)
                                                : (latest_y_reg - start_y_reg);
        travel  = MOVE_W'(dx) + MOVE_W'(dy);
        elapsed = evt.now - press_time_reg;
        if (travel > cfg.max_move)
            release_g = GEST_NONE;
        else if (elapsed < cfg.hold_limit)
            release_g = GEST_QUICK;
        else
            release_g = GEST_LONG;
    end

    // Next state and result for the current event
    always_comb
    begin
        is_down_next    = is_down_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        latest_x_next   = latest_x_reg;
        latest_y_next   = latest_y_reg;
        press_time_next = press_time_reg;
        saved_next      = saved_reg;
        res.gvalid      = 1'b0;
        res.code        = GEST_NONE;
        res.x           = '0;
        res.y           = '0;

        case (evt.kind)
            EV_DOWN:
            begin
                latest_x_next = evt.x;
                latest_y_next = evt.y;
                if (!is_down_reg)
                begin
                    is_down_next = 1'b1;
                    start_x_next = evt.x;
                    start_y_next = evt.y;
                    // debounce: keep the old press time on a quick re-press
                    if (elapsed > cfg.debounce_ms)
                        press_time_next = evt.now;
                    saved_next = GEST_PRESSED;
                    res.gvalid = 1'b1;
                    res.code   = GEST_PRESSED;
                    res.x      = evt.x;
                    res.y      = evt.y;
                end
            end
            EV_UP:
            begin
                is_down_next = 1'b0;
                if (is_down_reg)
                begin
                    saved_next = release_g;
                    if (release_g != GEST_NONE)
                    begin
                        res.gvalid = 1'b1;
                        res.code   = release_g;
                        res.x      = latest_x_reg;
                        res.y      = latest_y_reg;
                    end
                end
            end
            EV_MOVE:
            begin
                latest_x_next = evt.x;
                latest_y_next = evt.y;
            end
            default:
            begin
                is_down_next = is_down_reg;
            end
        endcase

        res.touching = is_down_next;
        res.recorded = saved_next;
    end

    // Touch state registers, advanced once per event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_down_reg    <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            latest_x_reg   <= '0;
            latest_y_reg   <= '0;
            press_time_reg <= '0;
            saved_reg      <= GEST_NONE;
        end
        else if (fire)
        begin
            is_down_reg    <= is_down_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            latest_x_reg   <= latest_x_next;
            latest_y_reg   <= latest_y_next;
            press_time_reg <= press_time_next;
            saved_reg      <= saved_next;
        end
    end

endmodule

/* design/ttlp_out_stage.sv */
// Result register of the classifier pipeline, held while the consumer stalls.
// Depends on ttlp_pkg.
module ttlp_out_stage
    import ttlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         out_stall,
    input  ttlp_result_t res_in,
    output logic         out_valid,
    output ttlp_result_t res
);

    logic         valid_reg;
    logic         valid_next;
    ttlp_result_t res_reg;

    // Full on load, empties once the consumer takes the transaction
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

/* design/ttlp_checker.sv */
// Port-level checks for the touch tap / long-press classifier, bound to the top.
// Depends on ttlp_pkg and touch_tap_long_press_classifier_top.
module ttlp_checker
    import ttlp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               gesture_valid,
    input logic [1:0]         gesture_code,
    input logic [COORD_W-1:0] gesture_x,
    input logic [COORD_W-1:0] gesture_y,
    input logic               touching,
    input logic [1:0]         recorded_gesture
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gesture_code)
            && $stable(gesture_x) && $stable(gesture_y) && $stable(recorded_gesture))
        else $error("result changed while stalled");

    // Without a notification the gesture fields are zero
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !gesture_valid |->
            gesture_code == GEST_NONE && gesture_x == '0 && gesture_y == '0)
        else $error("gesture fields not cleared without notification");

    // PRESSED starts a touch and is recorded
    a_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gesture_valid && gesture_code == GEST_PRESSED |->
            touching && recorded_gesture == GEST_PRESSED)
        else $error("pressed without touch in progress");

    // A click or long press ends the touch and is the recorded gesture
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gesture_valid
            && (gesture_code == GEST_QUICK || gesture_code == GEST_LONG) |->
            !touching && recorded_gesture == gesture_code)
        else $error("release gesture inconsistent with touch state");

    // A notification never carries code none
    a_code_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gesture_valid |-> gesture_code != GEST_NONE)
        else $error("notification with gesture none");

endmodule

bind touch_tap_long_press_classifier_top ttlp_checker u_ttlp_checker (.*);
